// ===== rtl/periodic_min_image_distance_defines.svh =====
`ifndef PERIODIC_MIN_IMAGE_DISTANCE_DEFINES_SVH
`define PERIODIC_MIN_IMAGE_DISTANCE_DEFINES_SVH

// Same-cycle implication, checked on aclk and disabled while aresetn is low.
`define PMID_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and disabled while aresetn is low.
`define PMID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pmid_pkg.sv =====
`timescale 1ns / 1ps

package pmid_pkg;

    // Field widths.
    localparam int COORD_BITS = 20;
    localparam int BOX_BITS   = 20;
    localparam int SQ_BITS    = 40;
    localparam int DIST_BITS  = 20;

    // Internal widths derived from the field widths.
    localparam int EFF_BITS    = (COORD_BITS > BOX_BITS) ? COORD_BITS : BOX_BITS;
    localparam int PROD_BITS   = 2 * EFF_BITS;
    localparam int SUM_BITS    = PROD_BITS + 2;
    localparam int REM_BITS    = SQ_BITS + 1;
    localparam int ROOT_STAGES = DIST_BITS;

    localparam logic [BOX_BITS-1:0] BOX_RESET = {BOX_BITS{1'b1}};
    localparam logic [SQ_BITS-1:0]  SQ_MAX    = {SQ_BITS{1'b1}};

    // One pair of particle positions.
    typedef struct packed {
        logic [COORD_BITS-1:0] a_x;
        logic [COORD_BITS-1:0] b_x;
        logic [COORD_BITS-1:0] a_y;
        logic [COORD_BITS-1:0] b_y;
        logic [COORD_BITS-1:0] a_z;
        logic [COORD_BITS-1:0] b_z;
    } pair_t;

    // Saturated squared distance handed from the front end to the root pipeline.
    typedef struct packed {
        logic [SQ_BITS-1:0] dist_squared;
        logic               out_of_box;
    } sum_t;

    // One result.
    typedef struct packed {
        logic [SQ_BITS-1:0]   dist_squared;
        logic [DIST_BITS-1:0] distance;
        logic                 out_of_box;
    } result_t;

endpackage

// ===== rtl/pmid_front.sv =====
`timescale 1ns / 1ps

module pmid_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pmid_pkg::BOX_BITS-1:0] box_length,
    input  logic                          advance,
    input  logic                          in_valid,
    input  pmid_pkg::pair_t               in_data,
    output logic                          in_ready,
    output logic                          sum_valid,
    output pmid_pkg::sum_t                sum_data
);
    import pmid_pkg::*;

    logic [COORD_BITS-1:0] a_c [3];
    logic [COORD_BITS-1:0] b_c [3];
    logic [COORD_BITS-1:0] mag_next [3];
    logic [EFF_BITS-1:0]   eff_next [3];
    logic                  oob_next;
    logic [SUM_BITS-1:0]   sum_full;
    logic                  load1;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic [COORD_BITS-1:0] mag_reg [3];
    logic [EFF_BITS-1:0]   eff_reg [3];
    logic [PROD_BITS-1:0]  sq_reg [3];
    logic                  oob1_reg, oob2_reg, oob3_reg, oob4_reg;
    logic [SQ_BITS-1:0]    dsq_reg;

    // The first stage may fill a bubble even while the rest of the pipeline holds.
    assign load1    = advance || !v1_reg;
    assign in_ready = load1;

    // Axis differences and the out-of-box check.
    always_comb begin
        a_c[0] = in_data.a_x;
        b_c[0] = in_data.b_x;
        a_c[1] = in_data.a_y;
        b_c[1] = in_data.b_y;
        a_c[2] = in_data.a_z;
        b_c[2] = in_data.b_z;
        oob_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            mag_next[k] = (a_c[k] >= b_c[k]) ? (a_c[k] - b_c[k]) : (b_c[k] - a_c[k]);
            if ((EFF_BITS'(a_c[k]) > EFF_BITS'(box_length)) ||
                (EFF_BITS'(b_c[k]) > EFF_BITS'(box_length))) begin
                oob_next = 1'b1;
            end
        end
    end

    // Minimum-image fold: a magnitude above half the box becomes its distance to the box.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if ({EFF_BITS'(mag_reg[k]), 1'b0} > {1'b0, EFF_BITS'(box_length)}) begin
                if (EFF_BITS'(mag_reg[k]) >= EFF_BITS'(box_length)) begin
                    eff_next[k] = EFF_BITS'(mag_reg[k]) - EFF_BITS'(box_length);
                end else begin
                    eff_next[k] = EFF_BITS'(box_length) - EFF_BITS'(mag_reg[k]);
                end
            end else begin
                eff_next[k] = EFF_BITS'(mag_reg[k]);
            end
        end
    end

    // Sum of the three squares.
    assign sum_full = SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (load1) begin
                v1_reg <= in_valid;
            end
            if (advance) begin
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (load1) begin
            mag_reg  <= mag_next;
            oob1_reg <= oob_next;
        end
        if (advance) begin
            eff_reg  <= eff_next;
            oob2_reg <= oob1_reg;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= PROD_BITS'(eff_reg[k]) * PROD_BITS'(eff_reg[k]);
            end
            oob3_reg <= oob2_reg;
            if (sum_full > SUM_BITS'(SQ_MAX)) begin
                dsq_reg <= SQ_MAX;
            end else begin
                dsq_reg <= sum_full[SQ_BITS-1:0];
            end
            oob4_reg <= oob3_reg;
        end
    end

    assign sum_valid              = v4_reg;
    assign sum_data.dist_squared  = dsq_reg;
    assign sum_data.out_of_box    = oob4_reg;

endmodule

// ===== rtl/pmid_isqrt.sv =====
`timescale 1ns / 1ps
`include "periodic_min_image_distance_defines.svh"

module pmid_isqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              sum_valid,
    input  pmid_pkg::sum_t    sum_data,
    output logic              res_valid,
    output pmid_pkg::result_t res_data
);
    import pmid_pkg::*;

    localparam int LAST = ROOT_STAGES - 1;

    logic [SQ_BITS-1:0]   rem_in   [ROOT_STAGES];
    logic [DIST_BITS-1:0] root_in  [ROOT_STAGES];
    logic [SQ_BITS-1:0]   rem_next [ROOT_STAGES];
    logic [DIST_BITS-1:0] root_next[ROOT_STAGES];

    logic [ROOT_STAGES-1:0] v_reg;
    logic [SQ_BITS-1:0]     rem_reg  [ROOT_STAGES];
    logic [DIST_BITS-1:0]   root_reg [ROOT_STAGES];
    logic [SQ_BITS-1:0]     dsq_reg  [ROOT_STAGES];
    logic                   oob_reg  [ROOT_STAGES];

    // One root bit per stage, most significant first. The remainder holds
    // value - root^2, and a bit is kept when its increment still fits.
    always_comb begin
        logic [REM_BITS-1:0] trial;
        int                  bit_pos;
        trial   = '0;
        bit_pos = 0;
        rem_in[0]  = sum_data.dist_squared;
        root_in[0] = '0;
        for (int j = 1; j < ROOT_STAGES; j++) begin
            rem_in[j]  = rem_reg[j-1];
            root_in[j] = root_reg[j-1];
        end
        for (int j = 0; j < ROOT_STAGES; j++) begin
            bit_pos = LAST - j;
            trial   = (REM_BITS'(root_in[j]) << (bit_pos + 1)) +
                      (REM_BITS'(1) << (2 * bit_pos));
            if ({1'b0, rem_in[j]} >= trial) begin
                rem_next[j]  = SQ_BITS'({1'b0, rem_in[j]} - trial);
                root_next[j] = root_in[j] | (DIST_BITS'(1) << bit_pos);
            end else begin
                rem_next[j]  = rem_in[j];
                root_next[j] = root_in[j];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (advance) begin
            v_reg <= {v_reg[ROOT_STAGES-2:0], sum_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int j = 0; j < ROOT_STAGES; j++) begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
            end
            dsq_reg[0] <= sum_data.dist_squared;
            oob_reg[0] <= sum_data.out_of_box;
            for (int j = 1; j < ROOT_STAGES; j++) begin
                dsq_reg[j] <= dsq_reg[j-1];
                oob_reg[j] <= oob_reg[j-1];
            end
        end
    end

    assign res_valid             = v_reg[LAST];
    assign res_data.dist_squared = dsq_reg[LAST];
    assign res_data.distance     = root_reg[LAST];
    assign res_data.out_of_box   = oob_reg[LAST];

    // The finished root is the floor of the square root of the value.
    `PMID_ASSERT_IMPL(a_root_not_high, v_reg[LAST],
        (REM_BITS'(root_reg[LAST]) * REM_BITS'(root_reg[LAST])) <= REM_BITS'(dsq_reg[LAST]),
        "Square root result is too large.")
    `PMID_ASSERT_IMPL(a_root_not_low, v_reg[LAST],
        ((REM_BITS'(root_reg[LAST]) + 1'b1) * (REM_BITS'(root_reg[LAST]) + 1'b1)) >
        REM_BITS'(dsq_reg[LAST]),
        "Square root result is too small.")
    `PMID_ASSERT_IMPL(a_rem_matches, v_reg[LAST],
        (REM_BITS'(rem_reg[LAST]) + REM_BITS'(root_reg[LAST]) * REM_BITS'(root_reg[LAST])) ==
        REM_BITS'(dsq_reg[LAST]),
        "Square root remainder does not match the value.")

endmodule

// ===== rtl/periodic_min_image_distance.sv =====
`timescale 1ns / 1ps

// Minimum-image distance between two particles in a cubic periodic box. Each
// transaction carries two positions (unsigned, 10 fraction bits) and yields the
// squared distance (20 fraction bits, saturated at 2^40 - 1), its floored square
// root (10 fraction bits) and a flag that is set when any coordinate exceeds the
// box length. The block takes one transaction per clock while results are taken
// and returns them in order through four front-end stages (difference, fold,
// square, sum) followed by one square-root stage per result bit. When the result
// is not taken the pipeline holds; its first stage can still take one more
// transaction if it is empty. Write box_length only while no transaction is in
// flight.

module periodic_min_image_distance (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pmid_pkg::BOX_BITS-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pmid_pkg::pair_t               s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pmid_pkg::result_t             m_data
);
    import pmid_pkg::*;

    logic [BOX_BITS-1:0] box_reg;
    logic                advance;
    logic                sum_valid;
    sum_t                sum_data;

    // Box length register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= BOX_RESET;
        end else if (cfg_wr_en) begin
            box_reg <= cfg_wr_data;
        end
    end

    // The whole pipeline moves when the output register is free or being taken.
    assign advance = !m_valid || m_ready;

    pmid_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .box_length (box_reg),
        .advance    (advance),
        .in_valid   (s_valid),
        .in_data    (s_data),
        .in_ready   (s_ready),
        .sum_valid  (sum_valid),
        .sum_data   (sum_data)
    );

    pmid_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .sum_valid (sum_valid),
        .sum_data  (sum_data),
        .res_valid (m_valid),
        .res_data  (m_data)
    );

endmodule

// ===== tb/distance_checker.sv =====
`timescale 1ns / 1ps

module distance_checker
    import pmid_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [BOX_BITS-1:0] cfg_wr_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  pair_t               s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  result_t             m_data,
    output int                  outstanding,
    output int                  fail_count
);

    localparam int PRINT_LIMIT = 30;

    // Box length as the block currently holds it, and results still owed.
    logic [BOX_BITS-1:0] box_len;
    result_t             expected_results[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
        box_len     = BOX_RESET;
    end

    // One line per mismatch, up to a limit, and every one is counted.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Square of one axis difference after the minimum-image fold.
    function automatic logic [SQ_BITS-1:0] folded_square(input logic [COORD_BITS-1:0] a,
                                                         input logic [COORD_BITS-1:0] b,
                                                         input logic [BOX_BITS-1:0] len);
        logic [EFF_BITS-1:0]   mag;
        logic [EFF_BITS-1:0]   eff;
        logic [EFF_BITS:0]     twice;
        logic [SQ_BITS-1:0]    sq;
        mag   = (a >= b) ? EFF_BITS'(a - b) : EFF_BITS'(b - a);
        twice = {mag, 1'b0};
        if (twice > {1'b0, EFF_BITS'(len)})
            eff = (mag >= len) ? EFF_BITS'(mag - len) : EFF_BITS'(len - mag);
        else
            eff = mag;
        sq = SQ_BITS'(eff) * SQ_BITS'(eff);
        return sq;
    endfunction

    // Floored square root, one result bit per iteration.
    function automatic logic [DIST_BITS-1:0] floor_root(input logic [SQ_BITS-1:0] v);
        logic [SQ_BITS+1:0] rem;
        logic [SQ_BITS+1:0] root;
        logic [SQ_BITS+1:0] probe;
        rem   = {2'b00, v};
        root  = '0;
        probe = (SQ_BITS + 2)'(1) << (SQ_BITS - 2);
        for (int i = 0; i < SQ_BITS / 2; i++) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[DIST_BITS-1:0];
    endfunction

    // Expected result for one pair under the given box length.
    function automatic result_t predict_distance(input pair_t p, input logic [BOX_BITS-1:0] len);
        result_t            r;
        logic [SQ_BITS+1:0] total;
        total = (SQ_BITS + 2)'(folded_square(p.a_x, p.b_x, len))
              + (SQ_BITS + 2)'(folded_square(p.a_y, p.b_y, len))
              + (SQ_BITS + 2)'(folded_square(p.a_z, p.b_z, len));
        r.dist_squared = (total > (SQ_BITS + 2)'(SQ_MAX)) ? SQ_MAX : total[SQ_BITS-1:0];
        r.distance     = floor_root(r.dist_squared);
        r.out_of_box   = (p.a_x > len) || (p.b_x > len) || (p.a_y > len) ||
                         (p.b_y > len) || (p.a_z > len) || (p.b_z > len);
        return r;
    endfunction

    // Compare each result transaction with the oldest prediction, then record new pairs.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            box_len = BOX_RESET;
            expected_results.delete();
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_data.dist_squared, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.dist_squared !== want.dist_squared)
                        report_mismatch("dist_squared", m_data.dist_squared,
                                        want.dist_squared);
                    if (m_data.distance !== want.distance)
                        report_mismatch("distance", m_data.distance, want.distance);
                    if (m_data.out_of_box !== want.out_of_box)
                        report_mismatch("out_of_box", m_data.out_of_box, want.out_of_box);
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_distance(s_data, box_len));
            if (cfg_wr_en)
                box_len = cfg_wr_data;
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pmid_pkg::*;

    localparam int NUM_SETTINGS     = 8;
    localparam int DIRECTED_SETTINGS = 3;
    localparam int RANDOM_PER_SETTING = 56;
    localparam int DRAIN_CYCLES     = 40;
    localparam int CYCLE_LIMIT      = 200000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [BOX_BITS-1:0] cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    pair_t               s_data;
    logic                m_valid;
    logic                m_ready = 1'b0;
    result_t             m_data;

    int                  outstanding;
    int                  fail_count;
    int                  pairs_sent = 0;
    logic [BOX_BITS-1:0] box_now = BOX_RESET;
    bit                  tx_steady = 1'b0;
    bit                  rx_steady = 1'b0;
    int                  stall_left = 0;

    always #6 aclk = ~aclk;

    periodic_min_image_distance DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    distance_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .outstanding(outstanding),
        .fail_count (fail_count)
    );

    // Idle length: mostly none, often short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Result side stalls at random, with stall-free stretches in between.
    always @(posedge aclk) begin
        int n;
        if ($urandom_range(0, 149) == 0)
            rx_steady <= ~rx_steady;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            n = idle_cycles();
            m_ready    <= (n == 0);
            stall_left <= (n == 0) ? 0 : n - 1;
        end
    end

    // Box length for each setting; the first keeps the reset value.
    function automatic logic [BOX_BITS-1:0] setting_box(input int idx);
        case (idx)
            1:       return BOX_BITS'(2048);
            2:       return '0;
            3:       return BOX_BITS'(1);
            4:       return BOX_BITS'($urandom_range(2, 1048574));
            5:       return BOX_BITS'($urandom_range(16, 4096));
            6:       return BOX_RESET;
            7:       return BOX_BITS'($urandom_range(1, 1048575));
            default: return BOX_RESET;
        endcase
    endfunction

    // Coordinates for one axis: mostly inside the box, some near the fold point,
    // some at the edges and some anywhere in the field range.
    function automatic void pick_axis(input logic [BOX_BITS-1:0] len,
                                      output logic [COORD_BITS-1:0] a,
                                      output logic [COORD_BITS-1:0] b);
        logic [COORD_BITS-1:0] edges[4];
        logic [COORD_BITS-1:0] span;
        int                    r;
        r = $urandom_range(0, 9);
        edges[0] = '0;
        edges[1] = len;
        edges[2] = len + 1'b1;
        edges[3] = '1;
        if (r == 0) begin
            a = COORD_BITS'($urandom);
            b = COORD_BITS'($urandom);
        end else if (r <= 2) begin
            a    = COORD_BITS'($urandom_range(0, len));
            span = (len >> 1) + COORD_BITS'($urandom_range(0, 2));
            b    = $urandom_range(0, 1) ? a + span : a - span;
        end else if (r == 3) begin
            a = edges[$urandom_range(0, 3)];
            b = edges[$urandom_range(0, 3)];
        end else begin
            a = COORD_BITS'($urandom_range(0, len));
            b = COORD_BITS'($urandom_range(0, len));
        end
    endfunction

    function automatic pair_t random_pair(input logic [BOX_BITS-1:0] len);
        pair_t p;
        pick_axis(len, p.a_x, p.b_x);
        pick_axis(len, p.a_y, p.b_y);
        pick_axis(len, p.a_z, p.b_z);
        return p;
    endfunction

    // Offer one pair, after an optional gap, and hold it until it is taken.
    task automatic send_pair(input pair_t p);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_steady = ~tx_steady;
        gap = tx_steady ? 0 : idle_cycles();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        pairs_sent++;
    endtask

    // Drop valid and wait until every result owed has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_box(input logic [BOX_BITS-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        box_now = v;
    endtask

    // Hard stop in case the block hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT,
                 outstanding);
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus: directed corners and random pairs under a series of box lengths.
    initial begin
        pair_t               p;
        logic [BOX_BITS-1:0] half;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int idx = 0; idx < NUM_SETTINGS; idx++) begin
            if (idx != 0) begin
                wait_idle();
                write_box(setting_box(idx));
            end
            // Zero and full-scale fields, the exact fold threshold, a coordinate
            // just outside the box, alternating bit patterns and sum saturation.
            if (idx < DIRECTED_SETTINGS) begin
                half = box_now >> 1;
                for (int k = 0; k < 8; k++) begin
                    p = '0;
                    case (k)
                        1: p = '1;
                        2: begin
                            p.a_x = box_now;
                            p.a_y = box_now;
                            p.a_z = box_now;
                        end
                        3: begin
                            p.a_x = half;
                            p.b_y = half + 1'b1;
                            p.a_z = COORD_BITS'(({1'b0, box_now} + 1'b1) >> 1);
                        end
                        4: p.b_y = box_now + 1'b1;
                        5: p = {3{20'hAAAAA, 20'h55555}};
                        6: p = {3{20'h55555, 20'hAAAAA}};
                        7: begin
                            p.a_x = '1;
                            p.b_y = '1;
                            p.a_z = '1;
                        end
                        default: p = '0;
                    endcase
                    send_pair(p);
                end
            end
            repeat (RANDOM_PER_SETTING) send_pair(random_pair(box_now));
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d particle pairs under %0d box lengths, %s", pairs_sent,
                 NUM_SETTINGS, "zero, one and full scale among them,");
        $display("with random gaps and stalls on both channels; %0d mismatches found.",
                 fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pmid_pkg.sv
rtl/pmid_front.sv
rtl/pmid_isqrt.sv
rtl/periodic_min_image_distance.sv
tb/distance_checker.sv
tb/tb.sv
